@@ design/ppc_pkg.sv @@
// ppc_pkg: types and constants of the preamp panel controller
// event codes, modes, remote command codes, register map and item payloads
// used by the interfaces, the top level and the checker
package ppc_pkg;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_KNOB_UP    = 3'd1,
    ACT_KNOB_DOWN  = 3'd2,
    ACT_BUTTON     = 3'd3,
    ACT_REMOTE     = 3'd4,
    ACT_POWER_FAIL = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_OFF    = 2'd2
  } mode_t;

  // remote commands on the amplifier address
  localparam logic [5:0] CMD_PHONO    = 6'd1;
  localparam logic [5:0] CMD_TUNER    = 6'd3;
  localparam logic [5:0] CMD_DISC     = 6'd7;
  localparam logic [5:0] CMD_MEDIA    = 6'd8;
  localparam logic [5:0] CMD_MUTE     = 6'd13;
  localparam logic [5:0] CMD_VOL_UP   = 6'd16;
  localparam logic [5:0] CMD_VOL_DOWN = 6'd17;
  localparam logic [5:0] CMD_LIGHT    = 6'd59;
  // remote command on the player address
  localparam logic [5:0] CMD_PLAY     = 6'd53;

  localparam logic [2:0] SRC_PHONO = 3'd1;
  localparam logic [2:0] SRC_MEDIA = 3'd2;
  localparam logic [2:0] SRC_DISC  = 3'd3;
  localparam logic [2:0] SRC_TUNER = 3'd4;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_AMP     = 2'd1;
  localparam logic [1:0] REG_PLAYER  = 2'd2;
  localparam logic [1:0] REG_START   = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [4:0]  AMP_RESET     = 5'h10;
  localparam logic [4:0]  PLAYER_RESET  = 5'h14;
  localparam logic [2:0]  START_RESET   = 3'd1;

  typedef struct packed {
    logic [2:0] action;
    logic       rc_toggle;
    logic [4:0] rc_address;
    logic [5:0] rc_command;
  } in_item_t;

  typedef struct packed {
    logic signed [9:0] volume_step;
    logic [2:0]        source_now;
    logic              source_changed;
    logic              muted_now;
    logic              backlight_on;
    logic [1:0]        mode_now;
    logic              gain_write;
    logic              mute_write;
    logic              save_request;
  } out_item_t;

endpackage

@@ design/ppc_if.sv @@
// ppc_if: valid/ready channels of the preamp panel controller
// event channel and result channel; payload types from ppc_pkg
interface ppc_in_if;
  logic               valid;
  logic               ready;
  ppc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppc_out_if;
  logic               valid;
  logic               ready;
  ppc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/preamp_panel_controller.sv @@
// preamp_panel_controller: event-driven front panel control core
// depends on ppc_pkg and the channel interfaces in ppc_if.sv
//
// One event item per clock cycle unless the result side stalls. An accepted event
// updates the panel state and its result item is in the output register in the
// cycle after; a new event is taken in every cycle in which the output register
// is empty or being read, so the rate is set only by the single result register
// on the output side. The apb registers are written in the access cycle and take
// effect on the next event; writing start_source also reloads the current source.
module preamp_panel_controller #(
  parameter int VOLUME_STEPS = 447,
  parameter int NUM_SOURCES  = 4
) (
  input  logic             clk,
  input  logic             rst,
  ppc_in_if.sink           evt,
  ppc_out_if.source        res,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic signed [9:0] VOL_MIN = 10'(-VOLUME_STEPS);
  localparam logic [2:0]        SRC_MAX = 3'(NUM_SOURCES);

  function automatic logic [2:0] start_value(input logic [2:0] v);
    if (v >= 3'd1 && v <= SRC_MAX) begin
      return v;
    end
    return 3'd1;
  endfunction

  // configuration
  logic [15:0] timeout_ticks;
  logic [4:0]  amp_address;
  logic [4:0]  player_address;
  logic [2:0]  start_source;

  // panel state
  logic signed [9:0] volume_reg;
  logic [2:0]        source_reg;
  logic              muted_flag;
  logic              light_flag;
  ppc_pkg::mode_t    mode_reg;
  logic              last_toggle;
  logic [15:0]       idle_count;

  logic signed [9:0] volume_next;
  logic [2:0]        source_next;
  logic              muted_next;
  logic              light_next;
  ppc_pkg::mode_t    mode_next;
  logic              toggle_next;
  logic [15:0]       idle_next;
  logic              gain_w;
  logic              mute_w;
  logic              src_chg;
  logic              save;
  logic              fresh;

  logic               out_valid;
  ppc_pkg::out_item_t out_data;
  logic               accept;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign evt.ready = !out_valid || res.ready;
  assign accept    = evt.valid && evt.ready;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  always_comb begin
    case (paddr[3:2])
      ppc_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      ppc_pkg::REG_AMP:     prdata = {27'd0, amp_address};
      ppc_pkg::REG_PLAYER:  prdata = {27'd0, player_address};
      ppc_pkg::REG_START:   prdata = {29'd0, start_source};
      default:              prdata = 32'd0;
    endcase
  end

  always_comb begin
    volume_next = volume_reg;
    source_next = source_reg;
    muted_next  = muted_flag;
    light_next  = light_flag;
    mode_next   = mode_reg;
    toggle_next = last_toggle;
    idle_next   = idle_count;
    gain_w      = 1'b0;
    mute_w      = 1'b0;
    src_chg     = 1'b0;
    save        = 1'b0;
    fresh       = evt.data.rc_toggle != last_toggle;

    case (evt.data.action)
      ppc_pkg::ACT_TICK: begin
        if (mode_reg == ppc_pkg::MODE_SELECT) begin
          if (idle_count >= timeout_ticks) begin
            mode_next = ppc_pkg::MODE_RUN;
            idle_next = 16'd0;
          end else begin
            idle_next = idle_count + 16'd1;
          end
        end
      end
      ppc_pkg::ACT_KNOB_UP: begin
        if (mode_reg == ppc_pkg::MODE_RUN) begin
          if (volume_reg < 10'sd0) begin
            if (muted_flag) begin
              light_next = 1'b1;
              muted_next = 1'b0;
            end
            volume_next = volume_reg + 10'sd1;
            gain_w      = 1'b1;
          end
        end else if (mode_reg == ppc_pkg::MODE_SELECT) begin
          idle_next   = 16'd0;
          source_next = (source_reg < SRC_MAX) ? source_reg + 3'd1 : 3'd1;
          src_chg     = 1'b1;
        end
      end
      ppc_pkg::ACT_KNOB_DOWN: begin
        if (mode_reg == ppc_pkg::MODE_RUN) begin
          if (volume_reg > VOL_MIN) begin
            if (muted_flag) begin
              light_next = 1'b1;
              muted_next = 1'b0;
            end
            volume_next = volume_reg - 10'sd1;
            gain_w      = 1'b1;
          end
        end else if (mode_reg == ppc_pkg::MODE_SELECT) begin
          idle_next   = 16'd0;
          source_next = (source_reg > 3'd1) ? source_reg - 3'd1 : SRC_MAX;
          src_chg     = 1'b1;
        end
      end
      ppc_pkg::ACT_BUTTON: begin
        if (mode_reg == ppc_pkg::MODE_RUN) begin
          mode_next = ppc_pkg::MODE_SELECT;
          idle_next = 16'd0;
        end
      end
      ppc_pkg::ACT_REMOTE: begin
        toggle_next = evt.data.rc_toggle;
        if (evt.data.rc_address == amp_address) begin
          case (evt.data.rc_command)
            ppc_pkg::CMD_PHONO, ppc_pkg::CMD_TUNER, ppc_pkg::CMD_DISC,
            ppc_pkg::CMD_MEDIA: begin
              if (fresh) begin
                // source pick wakes the panel if the light is off
                if (!light_flag) begin
                  light_next = 1'b1;
                  muted_next = 1'b0;
                  gain_w     = 1'b1;
                end
                case (evt.data.rc_command)
                  ppc_pkg::CMD_PHONO: source_next = ppc_pkg::SRC_PHONO;
                  ppc_pkg::CMD_TUNER: source_next = ppc_pkg::SRC_TUNER;
                  ppc_pkg::CMD_DISC:  source_next = ppc_pkg::SRC_DISC;
                  default:            source_next = ppc_pkg::SRC_MEDIA;
                endcase
                src_chg = 1'b1;
              end
            end
            ppc_pkg::CMD_MUTE: begin
              if (fresh) begin
                if (muted_flag) begin
                  light_next = 1'b1;
                  muted_next = 1'b0;
                  gain_w     = 1'b1;
                end else begin
                  muted_next = 1'b1;
                  mute_w     = 1'b1;
                end
              end
            end
            ppc_pkg::CMD_VOL_UP: begin
              if (muted_flag) begin
                light_next = 1'b1;
                muted_next = 1'b0;
                gain_w     = 1'b1;
              end
              if (volume_reg < 10'sd0) begin
                volume_next = volume_reg + 10'sd1;
                gain_w      = 1'b1;
              end
            end
            ppc_pkg::CMD_VOL_DOWN: begin
              if (muted_flag) begin
                light_next = 1'b1;
                muted_next = 1'b0;
                gain_w     = 1'b1;
              end
              if (volume_reg > VOL_MIN) begin
                volume_next = volume_reg - 10'sd1;
                gain_w      = 1'b1;
              end
            end
            ppc_pkg::CMD_LIGHT: begin
              if (fresh) begin
                if (light_flag) begin
                  light_next = 1'b0;
                  muted_next = 1'b1;
                  mute_w     = 1'b1;
                end else begin
                  light_next = 1'b1;
                  muted_next = 1'b0;
                  gain_w     = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end else if (evt.data.rc_address == player_address) begin
          if (fresh && evt.data.rc_command == ppc_pkg::CMD_PLAY) begin
            source_next = ppc_pkg::SRC_DISC;
            src_chg     = 1'b1;
          end
        end
      end
      ppc_pkg::ACT_POWER_FAIL: begin
        save       = 1'b1;
        light_next = 1'b0;
        muted_next = 1'b1;
        mute_w     = 1'b1;
        mode_next  = ppc_pkg::MODE_OFF;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= ppc_pkg::TIMEOUT_RESET;
      amp_address    <= ppc_pkg::AMP_RESET;
      player_address <= ppc_pkg::PLAYER_RESET;
      start_source   <= ppc_pkg::START_RESET;
      volume_reg     <= VOL_MIN;
      source_reg     <= start_value(ppc_pkg::START_RESET);
      muted_flag     <= 1'b0;
      light_flag     <= 1'b1;
      mode_reg       <= ppc_pkg::MODE_RUN;
      last_toggle    <= 1'b0;
      idle_count     <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        volume_reg  <= volume_next;
        muted_flag  <= muted_next;
        light_flag  <= light_next;
        mode_reg    <= mode_next;
        last_toggle <= toggle_next;
        idle_count  <= idle_next;
        out_valid   <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      // a start_source write reloads the current source
      if (cfg_write && paddr[3:2] == ppc_pkg::REG_START) begin
        source_reg <= start_value(pwdata[2:0]);
      end else if (accept) begin
        source_reg <= source_next;
      end
      if (cfg_write) begin
        case (paddr[3:2])
          ppc_pkg::REG_TIMEOUT: timeout_ticks  <= pwdata[15:0];
          ppc_pkg::REG_AMP:     amp_address    <= pwdata[4:0];
          ppc_pkg::REG_PLAYER:  player_address <= pwdata[4:0];
          ppc_pkg::REG_START:   start_source   <= pwdata[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  // result register, no reset needed on the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.volume_step    <= volume_next;
      out_data.source_now     <= source_next;
      out_data.source_changed <= src_chg;
      out_data.muted_now      <= muted_next;
      out_data.backlight_on   <= light_next;
      out_data.mode_now       <= mode_next;
      out_data.gain_write     <= gain_w;
      out_data.mute_write     <= mute_w;
      out_data.save_request   <= save;
    end
  end

endmodule

@@ design/ppc_checker.sv @@
// ppc_checker: port-level assertions for preamp_panel_controller
// depends on ppc_pkg; bound to the top level at the end of this file
module ppc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ppc_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every accepted item yields a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item without result");

  // power fail leaves the panel off, dark and muted
  a_save_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.save_request |->
      out_data.mode_now == ppc_pkg::MODE_OFF && out_data.muted_now &&
      !out_data.backlight_on)
    else $error("save without power-off state");

  // a gain write always leaves the output unmuted, a mute write muted; volume stays <= 0, source != 0
  a_write_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.gain_write && out_data.muted_now) &&
      !(out_data.mute_write && !out_data.muted_now) &&
      out_data.volume_step <= 10'sd0 && out_data.source_now != 3'd0)
    else $error("result flags inconsistent");

endmodule

bind preamp_panel_controller ppc_checker u_ppc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (evt.valid),
  .in_ready  (evt.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_data  (res.data)
);

@@ tb/ppc_panel_checker.sv @@
`timescale 1ns / 1ps
// ppc_panel_checker: watches the event, result and apb ports of the panel controller,
// predicts each result item and compares it; depends on ppc_pkg
module ppc_panel_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  input  logic               evt_ready,
  input  ppc_pkg::in_item_t  evt_data,
  input  logic               res_valid,
  input  logic               res_ready,
  input  ppc_pkg::out_item_t res_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int VOL_STEPS = 447;
  localparam int SRC_COUNT = 4;

  // register copies
  logic [15:0] cfg_timeout;
  logic [4:0]  cfg_amp_addr;
  logic [4:0]  cfg_player_addr;
  logic [2:0]  cfg_start_src;

  // panel state
  int             vol_now;
  logic [2:0]     src_sel;
  logic           mute_on;
  logic           light_on;
  ppc_pkg::mode_t panel_mode;
  logic           prev_toggle;
  logic [15:0]    select_idle;

  // per-item strobes
  logic        gain_hit;
  logic        mute_hit;
  logic        src_hit;

  ppc_pkg::out_item_t predicted_panels[$];
  int                 err_total = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [2:0] start_pick(logic [2:0] v);
    if (v >= ppc_pkg::SRC_PHONO && v <= 3'(SRC_COUNT)) return v;
    return ppc_pkg::SRC_PHONO;
  endfunction

  task reset_panel;
    cfg_timeout     = ppc_pkg::TIMEOUT_RESET;
    cfg_amp_addr    = ppc_pkg::AMP_RESET;
    cfg_player_addr = ppc_pkg::PLAYER_RESET;
    cfg_start_src   = ppc_pkg::START_RESET;
    vol_now         = -VOL_STEPS;
    src_sel         = start_pick(ppc_pkg::START_RESET);
    mute_on         = 1'b0;
    light_on        = 1'b1;
    panel_mode      = ppc_pkg::MODE_RUN;
    prev_toggle     = 1'b0;
    select_idle     = '0;
  endtask

  task apply_register(input logic [1:0] idx, input logic [31:0] v);
    case (idx)
      ppc_pkg::REG_TIMEOUT: cfg_timeout = v[15:0];
      ppc_pkg::REG_AMP:     cfg_amp_addr = v[4:0];
      ppc_pkg::REG_PLAYER:  cfg_player_addr = v[4:0];
      ppc_pkg::REG_START: begin
        cfg_start_src = v[2:0];
        src_sel = start_pick(v[2:0]);
      end
      default: ;
    endcase
  endtask

  task unmute_panel;
    light_on = 1'b1;
    mute_on  = 1'b0;
    gain_hit = 1'b1;
  endtask

  task mute_panel;
    mute_on  = 1'b1;
    mute_hit = 1'b1;
  endtask

  task raise_volume;
    if (vol_now < 0) begin
      vol_now++;
      gain_hit = 1'b1;
    end
  endtask

  task lower_volume;
    if (vol_now > -VOL_STEPS) begin
      vol_now--;
      gain_hit = 1'b1;
    end
  endtask

  task choose_source(input logic [2:0] s, input bit wake);
    if (wake && !light_on) unmute_panel();
    src_sel = s;
    src_hit = 1'b1;
  endtask

  task handle_remote(input ppc_pkg::in_item_t it);
    bit fresh;
    fresh = (it.rc_toggle != prev_toggle);
    if (it.rc_address == cfg_amp_addr) begin
      case (it.rc_command)
        ppc_pkg::CMD_PHONO: if (fresh) choose_source(ppc_pkg::SRC_PHONO, 1'b1);
        ppc_pkg::CMD_TUNER: if (fresh) choose_source(ppc_pkg::SRC_TUNER, 1'b1);
        ppc_pkg::CMD_DISC:  if (fresh) choose_source(ppc_pkg::SRC_DISC, 1'b1);
        ppc_pkg::CMD_MEDIA: if (fresh) choose_source(ppc_pkg::SRC_MEDIA, 1'b1);
        ppc_pkg::CMD_MUTE: begin
          if (fresh) begin
            if (mute_on) unmute_panel();
            else mute_panel();
          end
        end
        ppc_pkg::CMD_VOL_UP: begin
          if (mute_on) unmute_panel();
          raise_volume();
        end
        ppc_pkg::CMD_VOL_DOWN: begin
          if (mute_on) unmute_panel();
          lower_volume();
        end
        ppc_pkg::CMD_LIGHT: begin
          if (fresh) begin
            if (light_on) begin
              light_on = 1'b0;
              mute_panel();
            end else begin
              unmute_panel();
            end
          end
        end
        default: ;
      endcase
    end else if (it.rc_address == cfg_player_addr) begin
      if (fresh && it.rc_command == ppc_pkg::CMD_PLAY)
        choose_source(ppc_pkg::SRC_DISC, 1'b0);
    end
    prev_toggle = it.rc_toggle;
  endtask

  task handle_knob(input bit up);
    if (panel_mode == ppc_pkg::MODE_RUN) begin
      if (up) begin
        if (vol_now < 0) begin
          if (mute_on) unmute_panel();
          raise_volume();
        end
      end else begin
        if (vol_now > -VOL_STEPS) begin
          if (mute_on) unmute_panel();
          lower_volume();
        end
      end
    end else if (panel_mode == ppc_pkg::MODE_SELECT) begin
      select_idle = '0;
      if (up) src_sel = (src_sel < 3'(SRC_COUNT)) ? src_sel + 3'd1 : ppc_pkg::SRC_PHONO;
      else src_sel = (src_sel > ppc_pkg::SRC_PHONO) ? src_sel - 3'd1 : 3'(SRC_COUNT);
      src_hit = 1'b1;
    end
  endtask

  task advance_panel(input ppc_pkg::in_item_t it, output ppc_pkg::out_item_t r);
    logic save;
    save     = 1'b0;
    gain_hit = 1'b0;
    mute_hit = 1'b0;
    src_hit  = 1'b0;
    case (it.action)
      ppc_pkg::ACT_TICK: begin
        if (panel_mode == ppc_pkg::MODE_SELECT) begin
          if (select_idle >= cfg_timeout) begin
            panel_mode  = ppc_pkg::MODE_RUN;
            select_idle = '0;
          end else begin
            select_idle = select_idle + 16'd1;
          end
        end
      end
      ppc_pkg::ACT_KNOB_UP:   handle_knob(1'b1);
      ppc_pkg::ACT_KNOB_DOWN: handle_knob(1'b0);
      ppc_pkg::ACT_BUTTON: begin
        if (panel_mode == ppc_pkg::MODE_RUN) begin
          panel_mode  = ppc_pkg::MODE_SELECT;
          select_idle = '0;
        end
      end
      ppc_pkg::ACT_REMOTE: handle_remote(it);
      ppc_pkg::ACT_POWER_FAIL: begin
        save     = 1'b1;
        light_on = 1'b0;
        mute_panel();
        panel_mode = ppc_pkg::MODE_OFF;
      end
      default: ;
    endcase
    r.volume_step    = vol_now[9:0];
    r.source_now     = src_sel;
    r.source_changed = src_hit;
    r.muted_now      = mute_on;
    r.backlight_on   = light_on;
    r.mode_now       = panel_mode;
    r.gain_write     = gain_hit;
    r.mute_write     = mute_hit;
    r.save_request   = save;
  endtask

  task check_field(input string name, input logic signed [31:0] want,
                   input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    ppc_pkg::out_item_t fresh_pred;
    ppc_pkg::out_item_t want;
    if (rst) begin
      reset_panel();
      predicted_panels.delete();
    end else begin
      if (psel && penable && pwrite && pready) apply_register(paddr[3:2], pwdata);
      if (evt_valid && evt_ready) begin
        advance_panel(evt_data, fresh_pred);
        predicted_panels.push_back(fresh_pred);
      end
      if (res_valid && res_ready) begin
        if (predicted_panels.size() == 0) begin
          $error("result item with no event item waiting");
          err_total++;
        end else begin
          want = predicted_panels.pop_front();
          check_field("volume_step", 32'($signed(want.volume_step)),
                      32'($signed(res_data.volume_step)));
          check_field("source_now", 32'(want.source_now), 32'(res_data.source_now));
          check_field("source_changed", 32'(want.source_changed),
                      32'(res_data.source_changed));
          check_field("muted_now", 32'(want.muted_now), 32'(res_data.muted_now));
          check_field("backlight_on", 32'(want.backlight_on), 32'(res_data.backlight_on));
          check_field("mode_now", 32'(want.mode_now), 32'(res_data.mode_now));
          check_field("gain_write", 32'(want.gain_write), 32'(res_data.gain_write));
          check_field("mute_write", 32'(want.mute_write), 32'(res_data.mute_write));
          check_field("save_request", 32'(want.save_request), 32'(res_data.save_request));
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= predicted_panels.size();
  end

endmodule

@@ tb/tb_preamp_panel_controller.sv @@
`timescale 1ns / 1ps
// tb_preamp_panel_controller: drives panel events and apb register writes into the
// controller and gives the verdict; depends on ppc_pkg, ppc_if.sv and ppc_panel_checker
module tb_preamp_panel_controller;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [5:0] CMD_UNKNOWN  = 6'd63;
  localparam int LONG_HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;
  logic        long_hold;

  ppc_in_if  evt_ch ();
  ppc_out_if res_ch ();

  preamp_panel_controller dut (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppc_panel_checker panel_chk (
    .clk         (clk),
    .rst         (rst),
    .evt_valid   (evt_ch.valid),
    .evt_ready   (evt_ch.ready),
    .evt_data    (evt_ch.data),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_data    (res_ch.data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin : run_limit
    #2000000;
    $display("preamp_panel_controller verification failed");
    $finish;
  end

  // result side: stall pattern of its own, plus one long hold-off per request
  initial begin : res_drain
    int left;
    int stall_kind;
    left = 0;
    stall_kind = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if (left == 0) begin
          stall_kind = $urandom_range(0, 2);
          left = $urandom_range(10, 150);
        end
        left--;
        case (stall_kind)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // stimulus generation
  ppc_pkg::in_item_t event_plan[$];
  logic              gen_toggle;
  int                cur_timeout;
  logic [4:0]        cur_amp;
  logic [4:0]        cur_player;
  logic [5:0]        amp_cmds[8] = '{ppc_pkg::CMD_PHONO, ppc_pkg::CMD_TUNER,
                                     ppc_pkg::CMD_DISC, ppc_pkg::CMD_MEDIA,
                                     ppc_pkg::CMD_MUTE, ppc_pkg::CMD_VOL_UP,
                                     ppc_pkg::CMD_VOL_DOWN, ppc_pkg::CMD_LIGHT};

  task push_evt(input logic [2:0] act, input logic tog, input logic [4:0] addr,
                input logic [5:0] cmd);
    ppc_pkg::in_item_t it;
    it.action     = act;
    it.rc_toggle  = tog;
    it.rc_address = addr;
    it.rc_command = cmd;
    if (act == ppc_pkg::ACT_REMOTE) gen_toggle = tog;
    event_plan.push_back(it);
  endtask

  // remote fields carry garbage when the action ignores them
  task push_plain(input logic [2:0] act);
    push_evt(act, 1'($urandom), 5'($urandom), 6'($urandom));
  endtask

  task push_remote(input logic [4:0] addr, input logic [5:0] cmd, input bit fresh);
    push_evt(ppc_pkg::ACT_REMOTE, fresh ? ~gen_toggle : gen_toggle, addr, cmd);
  endtask

  task push_random_remote;
    int r;
    bit fresh;
    r = $urandom_range(0, 99);
    fresh = ($urandom_range(0, 3) != 0);
    if (r < 60)
      push_remote(cur_amp, ($urandom_range(0, 4) != 0) ? amp_cmds[$urandom_range(0, 7)]
                                                       : 6'($urandom), fresh);
    else if (r < 80)
      push_remote(cur_player, ($urandom_range(0, 9) < 7) ? ppc_pkg::CMD_PLAY : 6'($urandom),
                  fresh);
    else
      push_remote(5'($urandom), 6'($urandom), fresh);
  endtask

  task add_sequence(input int kw, input int sw, input int rw, input int tw, input int nw,
                    input int up_pct, input bit allow_off);
    int pick;
    int len;
    bit up;
    logic [2:0] act;
    pick = $urandom_range(0, kw + sw + rw + tw + nw - 1);
    if (pick < kw) begin
      len = $urandom_range(1, 32);
      up = ($urandom_range(1, 100) <= up_pct);
      repeat (len) push_plain(up ? ppc_pkg::ACT_KNOB_UP : ppc_pkg::ACT_KNOB_DOWN);
    end else if (pick < kw + sw) begin
      // select session: enter, wander, then time out where the timeout is short
      push_plain(ppc_pkg::ACT_BUTTON);
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 1))
          push_plain($urandom_range(0, 1) ? ppc_pkg::ACT_KNOB_UP : ppc_pkg::ACT_KNOB_DOWN);
        else repeat ($urandom_range(0, 3)) push_plain(ppc_pkg::ACT_TICK);
      end
      if (cur_timeout <= 20) repeat (cur_timeout + 1) push_plain(ppc_pkg::ACT_TICK);
      else repeat ($urandom_range(0, 6)) push_plain(ppc_pkg::ACT_TICK);
    end else if (pick < kw + sw + rw) begin
      repeat ($urandom_range(1, 8)) push_random_remote();
    end else if (pick < kw + sw + rw + tw) begin
      repeat ($urandom_range(1, 10)) push_plain(ppc_pkg::ACT_TICK);
    end else begin
      act = 3'($urandom_range(0, 7));
      if (act == ppc_pkg::ACT_POWER_FAIL && !allow_off) act = ACT_SPARE_LO;
      push_evt(act, 1'($urandom), 5'($urandom), 6'($urandom));
    end
  endtask

  task drive_plan;
    int burst;
    int gap;
    while (event_plan.size() > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && event_plan.size() > 0) begin
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= event_plan.pop_front();
        @(posedge clk);
        while (!evt_ch.ready) @(posedge clk);
        burst--;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0 && event_plan.size() > 0) begin
        evt_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    evt_ch.valid <= 1'b0;
  endtask

  // wait until every predicted result item has been taken
  task drain;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task write_reg(input logic [1:0] idx, input logic [31:0] val, input logic [31:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (val & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task write_all(input int timeout, input logic [4:0] amp, input logic [4:0] player,
                 input logic [2:0] start);
    cur_timeout = timeout;
    cur_amp     = amp;
    cur_player  = player;
    write_reg(ppc_pkg::REG_TIMEOUT, timeout, 32'h0000_ffff);
    write_reg(ppc_pkg::REG_AMP, 32'(amp), 32'h0000_001f);
    write_reg(ppc_pkg::REG_PLAYER, 32'(player), 32'h0000_001f);
    write_reg(ppc_pkg::REG_START, 32'(start), 32'h0000_0007);
  endtask

  task directed_opening;
    push_plain(ppc_pkg::ACT_KNOB_DOWN);            // already at the floor
    push_plain(ppc_pkg::ACT_KNOB_UP);
    push_remote(cur_amp, ppc_pkg::CMD_MUTE, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_MUTE, 1'b0); // repeat with same toggle
    push_plain(ppc_pkg::ACT_KNOB_UP);              // knob unmutes
    push_remote(cur_amp, ppc_pkg::CMD_LIGHT, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_PHONO, 1'b1); // wakes the dark panel
    push_remote(cur_amp, ppc_pkg::CMD_TUNER, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_DISC, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_MEDIA, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_MUTE, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_VOL_UP, 1'b0);
    push_remote(cur_amp, ppc_pkg::CMD_VOL_DOWN, 1'b0);
    push_remote(cur_player, ppc_pkg::CMD_PLAY, 1'b1);
    push_remote(5'd0, ppc_pkg::CMD_MUTE, 1'b1);     // nobody's address
    push_remote(cur_amp, CMD_UNKNOWN, 1'b1);
    push_plain(ppc_pkg::ACT_BUTTON);
    push_plain(ppc_pkg::ACT_KNOB_UP);
    push_plain(ppc_pkg::ACT_KNOB_UP);               // wraps to the first source
    push_plain(ppc_pkg::ACT_KNOB_DOWN);             // wraps back to the last
    push_plain(ppc_pkg::ACT_BUTTON);                // ignored in select mode
    repeat (3) push_plain(ppc_pkg::ACT_TICK);       // leaves select on the third tick
    push_plain(ACT_SPARE_LO);
    push_plain(ACT_SPARE_HI);
  endtask

  task off_prelude;
    push_plain(ppc_pkg::ACT_POWER_FAIL);
    push_plain(ppc_pkg::ACT_KNOB_UP);
    push_plain(ppc_pkg::ACT_KNOB_DOWN);
    push_plain(ppc_pkg::ACT_TICK);
    push_plain(ppc_pkg::ACT_BUTTON);
    push_remote(cur_amp, ppc_pkg::CMD_MUTE, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_PHONO, 1'b1);
    push_remote(cur_amp, ppc_pkg::CMD_VOL_UP, 1'b0);
    push_remote(cur_amp, ppc_pkg::CMD_LIGHT, 1'b1);
    push_plain(ppc_pkg::ACT_POWER_FAIL);
  endtask

  task run_phase(input int timeout, input logic [4:0] amp, input logic [4:0] player,
                 input logic [2:0] start, input int items, input int kw, input int sw,
                 input int rw, input int tw, input int nw, input int up_pct,
                 input bit allow_off);
    write_all(timeout, amp, player, start);
    if (allow_off) off_prelude();
    while (event_plan.size() < items) add_sequence(kw, sw, rw, tw, nw, up_pct, allow_off);
    long_hold = 1'b1;
    drive_plan();
    drain();
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    evt_ch.valid = 1'b0;
    evt_ch.data  = '0;
    long_hold    = 1'b0;
    gen_toggle   = 1'b0;
    cur_timeout  = int'(ppc_pkg::TIMEOUT_RESET);
    cur_amp      = ppc_pkg::AMP_RESET;
    cur_player   = ppc_pkg::PLAYER_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a look at the reset state before any register write
    push_plain(ppc_pkg::ACT_TICK);
    push_plain(ppc_pkg::ACT_KNOB_DOWN);
    drive_plan();
    drain();

    write_all(2, ppc_pkg::AMP_RESET, ppc_pkg::PLAYER_RESET, ppc_pkg::SRC_TUNER);
    directed_opening();
    drive_plan();
    drain();

    run_phase(3, ppc_pkg::AMP_RESET, ppc_pkg::PLAYER_RESET, ppc_pkg::SRC_MEDIA, 200,
              30, 15, 35, 15, 5, 50, 1'b0);
    // volume sweep up to the ceiling
    run_phase(4, 5'd0, 5'd31, ppc_pkg::SRC_DISC, 650, 70, 5, 20, 3, 2, 98, 1'b0);
    run_phase(65535, 5'd31, 5'd0, ppc_pkg::SRC_TUNER, 100, 30, 15, 35, 15, 5, 30, 1'b0);
    // equal addresses, start source zero
    run_phase(1, 5'd7, 5'd7, 3'd0, 100, 30, 15, 35, 15, 5, 50, 1'b0);
    // start source beyond the last input
    run_phase(2, ppc_pkg::AMP_RESET, ppc_pkg::PLAYER_RESET, 3'd6, 100,
              20, 10, 55, 10, 5, 50, 1'b0);
    run_phase($urandom_range(1, 12), 5'($urandom), 5'($urandom), 3'($urandom_range(0, 7)),
              100, 30, 15, 35, 15, 5, 50, 1'b0);
    // powered off for the rest of the run
    run_phase(int'(ppc_pkg::TIMEOUT_RESET), ppc_pkg::AMP_RESET, ppc_pkg::PLAYER_RESET, 3'd7,
              120, 5, 5, 70, 5, 15, 50, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("preamp_panel_controller verification clean");
    end else begin
      $display("preamp_panel_controller verification failed");
    end
    $finish;
  end

endmodule
